// ----- design/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, register indexes, reset values and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

   // Fixed widths of the register file and the iteration count.
   localparam int REG_BITS       = 32;
   localparam int COUNT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Width of one operand slice of the shared multipliers.
   localparam int LIMB_BITS = 32;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ITERATIONS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_ORIGIN       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_STEP         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_ORIGIN       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_STEP         = 3'd4;

   // Register values after reset: limit 1000, origin -2.0, step 1/256.
   localparam logic [COUNT_BITS-1:0]      MAX_ITERATIONS_RESET = 16'd1000;
   localparam logic signed [REG_BITS-1:0] ORIGIN_RESET         = 32'shE000_0000;
   localparam logic signed [REG_BITS-1:0] STEP_RESET           = 32'sh0010_0000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the pixel indexes of an accepted request
      logic init_c;     // form c and take it as the first z
      logic load_mag;   // take |x|, |y| and signs, clear the accumulators
      logic mul_step;   // accumulate one set of partial products
      logic advance;    // commit the next z and bump the count
      logic emit;       // load the result register
   } mbe_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic big;        // a component of z is at least 2.0
      logic mul_last;   // current partial product is the last one
      logic stop;       // |z|^2 reached 4.0 or the count reached its limit
   } mbe_status_type;

endpackage

`default_nettype wire

// ----- design/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences one pixel at a time through seeding, magnitude test, multiply and
// escape check, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_ctrl
   import mbe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire mbe_status_type status,
   output mbe_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_TEST  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init_c = 1'b1;
            state_in   = S_TEST;
         end
         S_TEST: begin
            cmd.load_mag = 1'b1;
            state_in     = status.big ? S_DONE : S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.stop) begin
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_TEST;
            end
         end
         S_DONE: begin
            // The result register takes the item once it is empty or draining.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/mbe_datapath.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Holds the register file, the point c, the iterate z and the count, and a
// limb-serial unit that forms x*x, y*y and x*y with three 32x32 multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_datapath
   import mbe_pkg::*;
#(
   parameter int COLUMN_BITS   = 12,
   parameter int ROW_BITS      = 12,
   parameter int FRACTION_BITS = 28
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [REG_BITS-1:0]       csr_data,
   input  wire logic [COLUMN_BITS-1:0]    req_column,
   input  wire logic [ROW_BITS-1:0]       req_row,
   input  wire mbe_cmd_type               cmd,
   output mbe_status_type                 status,
   output logic [COLUMN_BITS-1:0]         rsp_column,
   output logic [ROW_BITS-1:0]            rsp_row,
   output logic [COUNT_BITS-1:0]          rsp_count
);

   // Magnitudes below 2.0 need one integer bit above the fraction.
   localparam int MAG_BITS  = FRACTION_BITS + 1;
   localparam int IDX_BITS  = (COLUMN_BITS > ROW_BITS) ? COLUMN_BITS : ROW_BITS;
   // origin + index * step, exact.
   localparam int C_BITS    = REG_BITS + IDX_BITS + 2;
   // Room for x2 - y2 + cx and 2xy + cy without wrap.
   localparam int V_BITS    = ((FRACTION_BITS + 4 > C_BITS) ? FRACTION_BITS + 4 : C_BITS) + 1;
   localparam int LIMBS     = (MAG_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int PAD_BITS  = LIMBS * LIMB_BITS;
   localparam int ACC_BITS  = 2 * MAG_BITS;
   localparam int WIDE_BITS = 2 * PAD_BITS;
   localparam int LIDX_BITS = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int SH_BITS   = $clog2(WIDE_BITS) + 1;

   // Register file.
   logic        [COUNT_BITS-1:0] max_iter_ff,  max_iter_in;
   logic signed [REG_BITS-1:0]   x_origin_ff,  x_origin_in;
   logic signed [REG_BITS-1:0]   x_step_ff,    x_step_in;
   logic signed [REG_BITS-1:0]   y_origin_ff,  y_origin_in;
   logic signed [REG_BITS-1:0]   y_step_ff,    y_step_in;

   // Pixel and iteration state.
   logic [COLUMN_BITS-1:0]     col_ff,   col_in;
   logic [ROW_BITS-1:0]        row_ff,   row_in;
   logic signed [V_BITS-1:0]   cx_ff,    cx_in;
   logic signed [V_BITS-1:0]   cy_ff,    cy_in;
   logic signed [V_BITS-1:0]   x_ff,     x_in;
   logic signed [V_BITS-1:0]   y_ff,     y_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic [MAG_BITS-1:0]        mx_ff,    mx_in;
   logic [MAG_BITS-1:0]        my_ff,    my_in;
   logic                       xneg_ff,  xneg_in;
   logic                       yneg_ff,  yneg_in;
   logic [LIDX_BITS-1:0]       li_ff,    li_in;
   logic [LIDX_BITS-1:0]       lj_ff,    lj_in;
   logic [ACC_BITS-1:0]        acc_xx_ff, acc_xx_in;
   logic [ACC_BITS-1:0]        acc_yy_ff, acc_yy_in;
   logic [ACC_BITS-1:0]        acc_xy_ff, acc_xy_in;

   // Result register.
   logic [COLUMN_BITS-1:0] rsp_col_ff,   rsp_col_in;
   logic [ROW_BITS-1:0]    rsp_row_ff,   rsp_row_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   // Seeding: c = origin + index * step.
   logic signed [IDX_BITS:0]          col_s;
   logic signed [IDX_BITS:0]          row_s;
   logic signed [REG_BITS+IDX_BITS:0] cx_prod;
   logic signed [REG_BITS+IDX_BITS:0] cy_prod;
   logic signed [C_BITS-1:0]          cx_calc;
   logic signed [C_BITS-1:0]          cy_calc;

   assign col_s   = $signed({1'b0, IDX_BITS'(col_ff)});
   assign row_s   = $signed({1'b0, IDX_BITS'(row_ff)});
   assign cx_prod = x_step_ff * col_s;
   assign cy_prod = y_step_ff * row_s;
   assign cx_calc = C_BITS'(cx_prod) + C_BITS'(x_origin_ff);
   assign cy_calc = C_BITS'(cy_prod) + C_BITS'(y_origin_ff);

   // Magnitudes of z and the test against 2.0.
   logic [V_BITS-1:0] xmag;
   logic [V_BITS-1:0] ymag;

   assign xmag = x_ff[V_BITS-1] ? V_BITS'(-x_ff) : V_BITS'(x_ff);
   assign ymag = y_ff[V_BITS-1] ? V_BITS'(-y_ff) : V_BITS'(y_ff);

   // Limb-serial products: one slice of each operand per cycle.
   logic [PAD_BITS-1:0]    mx_pad;
   logic [PAD_BITS-1:0]    my_pad;
   logic [LIMB_BITS-1:0]   xa, xb, ya, yb;
   logic [2*LIMB_BITS-1:0] pp_xx, pp_yy, pp_xy;
   logic [LIDX_BITS:0]     lsum;
   logic [SH_BITS-1:0]     shamt;
   logic [WIDE_BITS-1:0]   pp_xx_w, pp_yy_w, pp_xy_w;
   logic                   li_last, lj_last;

   assign mx_pad  = PAD_BITS'(mx_ff);
   assign my_pad  = PAD_BITS'(my_ff);
   assign xa      = mx_pad[li_ff*LIMB_BITS +: LIMB_BITS];
   assign xb      = mx_pad[lj_ff*LIMB_BITS +: LIMB_BITS];
   assign ya      = my_pad[li_ff*LIMB_BITS +: LIMB_BITS];
   assign yb      = my_pad[lj_ff*LIMB_BITS +: LIMB_BITS];
   assign pp_xx   = xa * xb;
   assign pp_yy   = ya * yb;
   assign pp_xy   = xa * yb;
   assign lsum    = {1'b0, li_ff} + {1'b0, lj_ff};
   assign shamt   = SH_BITS'(lsum) * SH_BITS'(LIMB_BITS);
   assign pp_xx_w = WIDE_BITS'(pp_xx) << shamt;
   assign pp_yy_w = WIDE_BITS'(pp_yy) << shamt;
   assign pp_xy_w = WIDE_BITS'(pp_xy) << shamt;
   assign li_last = (li_ff == LIDX_BITS'(LIMBS - 1));
   assign lj_last = (lj_ff == LIDX_BITS'(LIMBS - 1));

   // Escape test: x^2 + y^2 >= 4.0 is the top carry of the square sum.
   logic [ACC_BITS:0] sq_sum;

   assign sq_sum = {1'b0, acc_xx_ff} + {1'b0, acc_yy_ff};

   // Next iterate: x' = x^2 - y^2 + cx, y' = 2xy + cy, truncated toward zero.
   logic signed [V_BITS-1:0] x2_s, y2_s, t_s, p_s, x_next, y_next;

   assign x2_s   = V_BITS'(acc_xx_ff[ACC_BITS-1:FRACTION_BITS]);
   assign y2_s   = V_BITS'(acc_yy_ff[ACC_BITS-1:FRACTION_BITS]);
   assign t_s    = V_BITS'(acc_xy_ff[ACC_BITS-1:FRACTION_BITS-1]);
   assign p_s    = (xneg_ff ^ yneg_ff) ? -t_s : t_s;
   assign x_next = x2_s - y2_s + cx_ff;
   assign y_next = p_s + cy_ff;

   assign status.big      = (|xmag[V_BITS-1:MAG_BITS]) | (|ymag[V_BITS-1:MAG_BITS]);
   assign status.mul_last = li_last & lj_last;
   assign status.stop     = sq_sum[ACC_BITS] | (count_ff >= max_iter_ff);

   // Register file writes; unknown indexes are dropped.
   always_comb begin
      max_iter_in = max_iter_ff;
      x_origin_in = x_origin_ff;
      x_step_in   = x_step_ff;
      y_origin_in = y_origin_ff;
      y_step_in   = y_step_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_ITERATIONS: max_iter_in = csr_data[COUNT_BITS-1:0];
            CSR_X_ORIGIN:       x_origin_in = $signed(csr_data);
            CSR_X_STEP:         x_step_in   = $signed(csr_data);
            CSR_Y_ORIGIN:       y_origin_in = $signed(csr_data);
            CSR_Y_STEP:         y_step_in   = $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   // Iteration state updates.
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      count_in     = count_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      xneg_in      = xneg_ff;
      yneg_in      = yneg_ff;
      li_in        = li_ff;
      lj_in        = lj_ff;
      acc_xx_in    = acc_xx_ff;
      acc_yy_in    = acc_yy_ff;
      acc_xy_in    = acc_xy_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_count_in = rsp_count_ff;

      if (cmd.capture) begin
         col_in = req_column;
         row_in = req_row;
      end

      // The first pass starts from z = 0, so z becomes c with count one.
      if (cmd.init_c) begin
         cx_in    = V_BITS'(cx_calc);
         cy_in    = V_BITS'(cy_calc);
         x_in     = V_BITS'(cx_calc);
         y_in     = V_BITS'(cy_calc);
         count_in = COUNT_BITS'(1);
      end

      if (cmd.load_mag) begin
         mx_in     = xmag[MAG_BITS-1:0];
         my_in     = ymag[MAG_BITS-1:0];
         xneg_in   = x_ff[V_BITS-1];
         yneg_in   = y_ff[V_BITS-1];
         li_in     = '0;
         lj_in     = '0;
         acc_xx_in = '0;
         acc_yy_in = '0;
         acc_xy_in = '0;
      end

      if (cmd.mul_step) begin
         acc_xx_in = acc_xx_ff + pp_xx_w[ACC_BITS-1:0];
         acc_yy_in = acc_yy_ff + pp_yy_w[ACC_BITS-1:0];
         acc_xy_in = acc_xy_ff + pp_xy_w[ACC_BITS-1:0];
         if (!lj_last) begin
            lj_in = lj_ff + LIDX_BITS'(1);
         end else if (!li_last) begin
            lj_in = '0;
            li_in = li_ff + LIDX_BITS'(1);
         end
      end

      if (cmd.advance) begin
         x_in     = x_next;
         y_in     = y_next;
         count_in = count_ff + COUNT_BITS'(1);
      end

      if (cmd.emit) begin
         rsp_col_in   = col_ff;
         rsp_row_in   = row_ff;
         rsp_count_in = count_ff;
      end
   end

   // Registers; configuration and slice counters are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITERATIONS_RESET;
         x_origin_ff <= ORIGIN_RESET;
         x_step_ff   <= STEP_RESET;
         y_origin_ff <= ORIGIN_RESET;
         y_step_ff   <= STEP_RESET;
         li_ff       <= '0;
         lj_ff       <= '0;
      end else begin
         max_iter_ff <= max_iter_in;
         x_origin_ff <= x_origin_in;
         x_step_ff   <= x_step_in;
         y_origin_ff <= y_origin_in;
         y_step_ff   <= y_step_in;
         li_ff       <= li_in;
         lj_ff       <= lj_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      count_ff     <= count_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      xneg_ff      <= xneg_in;
      yneg_ff      <= yneg_in;
      acc_xx_ff    <= acc_xx_in;
      acc_yy_ff    <= acc_yy_in;
      acc_xy_ff    <= acc_xy_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_column = rsp_col_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

`default_nettype wire

// ----- design/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time evaluator
// Evaluates one pixel per request: forms c from the pixel indexes and the
// origin and step registers, iterates z = z*z + c and returns the pass count.
// ----------------------------------------------------------------------------
// Usage:
// A request transfer on req_* carries a pixel column and row. The block forms
// c = origin + index * step in fixed point and iterates until |z|^2 reaches
// 4.0, a component of z reaches 2.0, or the count reaches max_iterations.
// The response on rsp_* echoes the indexes with the pass count (at least 1).
// Pixels are worked one at a time. Each pass loads the magnitudes of z, walks
// the three shared multipliers through all L*L slice pairs, where
// L = ceil((FRACTION_BITS + 1) / 32) is the number of 32-bit slices, and then
// checks for escape; a component of 2.0 or more ends the pixel before the
// multiply. The response sits in an output register, so the next request is
// taken while an earlier response waits; a stalled receiver blocks only the
// pixel that finishes after it. Registers are to be written on csr_* only
// while the block is idle; the block itself does not enforce this.
// csr_ready is always high and unknown indexes are ignored.
// Reset clears the control, restores the register defaults (limit 1000,
// origins -2.0, steps 1/256) and drops any pending response.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time
   import mbe_pkg::*;
#(
   parameter int COLUMN_BITS   = 12,
   parameter int ROW_BITS      = 12,
   parameter int FRACTION_BITS = 28
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request: pixel_column, pixel_row, zero fill.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [((COLUMN_BITS+ROW_BITS+7)/8)*8-1:0] req_tdata,
   // Response: result_column, result_row, escape_count, zero fill.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [((COLUMN_BITS+ROW_BITS+COUNT_BITS+7)/8)*8-1:0] rsp_tdata,
   // Register writes.
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [REG_BITS-1:0]       csr_data
);

   localparam int RSP_W = ((COLUMN_BITS + ROW_BITS + COUNT_BITS + 7) / 8) * 8;

   mbe_cmd_type            cmd;
   mbe_status_type         status;
   logic [COLUMN_BITS-1:0] rsp_column;
   logic [ROW_BITS-1:0]    rsp_row;
   logic [COUNT_BITS-1:0]  rsp_count;

   assign csr_ready = 1'b1;

   // Sequencer.
   mbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic, registers and result register.
   mbe_datapath #(
      .COLUMN_BITS   (COLUMN_BITS),
      .ROW_BITS      (ROW_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_column (req_tdata[COLUMN_BITS-1:0]),
      .req_row    (req_tdata[COLUMN_BITS+ROW_BITS-1:COLUMN_BITS]),
      .cmd        (cmd),
      .status     (status),
      .rsp_column (rsp_column),
      .rsp_row    (rsp_row),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = RSP_W'({rsp_count, rsp_row, rsp_column});

endmodule

`default_nettype wire

// ----- design/mbe_checker.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time port checker
// Watches the top-level channels: response stability under stall, nonzero
// counts, and the number of pixels in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_checker #(
   parameter int COLUMN_BITS = 12,
   parameter int ROW_BITS    = 12
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((COLUMN_BITS+ROW_BITS+16+7)/8)*8-1:0] rsp_tdata
);

   localparam int CNT_LO = COLUMN_BITS + ROW_BITS;

   // Pixels accepted but not yet delivered.
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   assign pending_in = pending_ff + 2'(req_tvalid & req_tready)
                                  - 2'(rsp_tvalid & rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every pixel takes at least one pass.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[CNT_LO+15:CNT_LO] != 16'd0)
      else $error("escape count of zero");

   // A new request is taken only when no pixel is still being iterated.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> pending_ff <= 2'd1)
      else $error("request taken while a pixel is in work");

   // A response is shown only for an accepted request.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response without a request");

endmodule

bind mandelbrot_escape_time mbe_checker #(
   .COLUMN_BITS (COLUMN_BITS),
   .ROW_BITS    (ROW_BITS)
) u_mbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- dv/tb_mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time evaluator testbench
// Drives pixel requests through the stream ports and predicts each pass
// count with a fixed-point iteration of its own. Every response is compared
// field by field against the oldest pending prediction. Directed views cover
// escapes at once, points that never leave the set and the register extremes.
// Random views with different idle and stall patterns follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mandelbrot_escape_time
   import mbe_pkg::*;
();

   localparam int COLUMN_BITS   = 12;
   localparam int ROW_BITS      = 12;
   localparam int FRACTION_BITS = 28;
   localparam int REQ_BITS      = ((COLUMN_BITS + ROW_BITS + 7) / 8) * 8;
   localparam int RSP_BITS      = ((COLUMN_BITS + ROW_BITS + COUNT_BITS + 7) / 8) * 8;
   localparam int HANG_LIMIT    = 1000000;
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_LIMIT  = 10;

   // Fixed-point bounds of the escape tests: 2.0 per component, 4.0 for |z|^2.
   localparam logic [63:0]  TWO_FIXED  = 64'd2 << FRACTION_BITS;
   localparam logic [127:0] FOUR_WIDE  = 128'd1 << (2 * FRACTION_BITS + 2);

   typedef struct packed {
      logic [COLUMN_BITS-1:0] column;
      logic [ROW_BITS-1:0]    row;
      logic [COUNT_BITS-1:0]  count;
   } pixel_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // Request: pixel_column, pixel_row, zero fill.
   logic [REQ_BITS-1:0]       req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // Response: result_column, result_row, escape_count, zero fill.
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [REG_BITS-1:0]       csr_data = '0;

   // Register copies used by the predictor.
   logic [COUNT_BITS-1:0]      limit_reg    = MAX_ITERATIONS_RESET;
   logic signed [REG_BITS-1:0] x_origin_reg = ORIGIN_RESET;
   logic signed [REG_BITS-1:0] x_step_reg   = STEP_RESET;
   logic signed [REG_BITS-1:0] y_origin_reg = ORIGIN_RESET;
   logic signed [REG_BITS-1:0] y_step_reg   = STEP_RESET;

   pixel_result_type pending_pixels[$];
   int               mismatch_count = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               quiet_cycles   = 0;

   mandelbrot_escape_time #(
      .COLUMN_BITS   (COLUMN_BITS),
      .ROW_BITS      (ROW_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Absolute value of a 64-bit fixed-point number.
   function automatic logic [63:0] magnitude(input logic signed [63:0] value);
      return value[63] ? 64'(-value) : 64'(value);
   endfunction

   // Number of passes of z = z*z + c until escape or the iteration limit.
   function automatic logic [COUNT_BITS-1:0] escape_passes(
      input logic [COLUMN_BITS-1:0] column,
      input logic [ROW_BITS-1:0]    row
   );
      logic signed [63:0] column_s, row_s, cx, cy, x, y, x_sq, y_sq, cross_term;
      logic [63:0]        mag_x, mag_y, cross_mag;
      logic [127:0]       wide_xy, wide_x, wide_y;
      int unsigned        passes;
      bit                 done;
      column_s = {{(64-COLUMN_BITS){1'b0}}, column};
      row_s    = {{(64-ROW_BITS){1'b0}}, row};
      cx       = 64'(x_origin_reg) + column_s * 64'(x_step_reg);
      cy       = 64'(y_origin_reg) + row_s * 64'(y_step_reg);
      x        = '0;
      y        = '0;
      x_sq     = '0;
      y_sq     = '0;
      passes   = 0;
      done     = 1'b0;
      while (!done) begin
         // Cross term 2*x*y from the previous z, truncated toward zero.
         wide_xy    = {64'b0, magnitude(x)} * {64'b0, magnitude(y)};
         cross_mag  = 64'(wide_xy >> (FRACTION_BITS - 1));
         cross_term = (x[63] != y[63]) ? -$signed(cross_mag) : $signed(cross_mag);
         x          = x_sq - y_sq + cx;
         y          = cross_term + cy;
         passes++;
         mag_x     = magnitude(x);
         mag_y     = magnitude(y);
         if (mag_x >= TWO_FIXED || mag_y >= TWO_FIXED) begin
            done = 1'b1;
         end else begin
            wide_x = {64'b0, mag_x} * {64'b0, mag_x};
            wide_y = {64'b0, mag_y} * {64'b0, mag_y};
            if (wide_x + wide_y >= FOUR_WIDE || passes >= limit_reg) begin
               done = 1'b1;
            end else begin
               x_sq = $signed(64'(wide_x >> FRACTION_BITS));
               y_sq = $signed(64'(wide_y >> FRACTION_BITS));
            end
         end
      end
      return COUNT_BITS'(passes);
   endfunction

   // Register update as the block applies it; unused indexes change nothing.
   function automatic void apply_register(input logic [CSR_INDEX_BITS-1:0] index,
                                          input logic [REG_BITS-1:0] value);
      case (index)
         CSR_MAX_ITERATIONS: limit_reg    = value[COUNT_BITS-1:0];
         CSR_X_ORIGIN:       x_origin_reg = value;
         CSR_X_STEP:         x_step_reg   = value;
         CSR_Y_ORIGIN:       y_origin_reg = value;
         CSR_Y_STEP:         y_step_reg   = value;
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(input string field, input int unsigned expected,
                                         input int unsigned actual);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("mismatch on %s: expected %0d, got %0d", field, expected, actual);
      end
      mismatch_count++;
   endfunction

   // One register write transfer; the predictor copy follows at acceptance.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [REG_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One pixel request transfer, with random idle cycles ahead of it.
   task automatic send_pixel(input logic [COLUMN_BITS-1:0] column,
                             input logic [ROW_BITS-1:0] row);
      pixel_result_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'({row, column});
      do @(posedge clock); while (!req_tready);
      predicted.column = column;
      predicted.row    = row;
      predicted.count  = escape_passes(column, row);
      pending_pixels.push_back(predicted);
   endtask

   // Stop sending and wait until every predicted response has arrived.
   task automatic drain_pixels();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic restore_defaults();
      write_reg(CSR_MAX_ITERATIONS, REG_BITS'(MAX_ITERATIONS_RESET));
      write_reg(CSR_X_ORIGIN, ORIGIN_RESET);
      write_reg(CSR_X_STEP, STEP_RESET);
      write_reg(CSR_Y_ORIGIN, ORIGIN_RESET);
      write_reg(CSR_Y_STEP, STEP_RESET);
   endtask

   // Reset view: c = -2 + index/256 on both axes.
   task automatic test_default_view();
      send_pixel(12'd0, 12'd0);          // component at least 2 on the first pass
      send_pixel(12'd4095, 12'd4095);    // far corner
      send_pixel(12'd512, 12'd512);      // c = 0 never escapes
      send_pixel(12'd256, 12'd512);      // c = -1, period two
      send_pixel(12'd512, 12'd768);      // c = i, preperiodic
      send_pixel(12'd576, 12'd512);      // c = 0.25, slow cusp
      send_pixel(12'd577, 12'd512);      // just outside the cusp
      send_pixel(12'd1024, 12'd512);     // real part exactly 2.0
      send_pixel(12'd1023, 12'd512);     // just under 2.0
      send_pixel(12'd512, 12'd1024);     // imaginary part exactly 2.0
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      drain_pixels();
   endtask

   // Zero limit acts like one; small limits cut inside points short.
   task automatic test_iteration_limits();
      write_reg(CSR_MAX_ITERATIONS, 32'd0);
      send_pixel(12'd512, 12'd512);
      drain_pixels();
      write_reg(CSR_MAX_ITERATIONS, 32'hFFFF_0001);  // upper bits are dropped
      send_pixel(12'd512, 12'd512);
      send_pixel(12'd0, 12'd0);
      drain_pixels();
      write_reg(CSR_MAX_ITERATIONS, 32'd2);
      send_pixel(12'd256, 12'd512);
      drain_pixels();
      write_reg(CSR_MAX_ITERATIONS, REG_BITS'(MAX_ITERATIONS_RESET));
   endtask

   // Writes to indexes past the last register must leave the view unchanged.
   task automatic test_unused_indexes();
      for (int index = CSR_Y_STEP + 1; index < 2 ** CSR_INDEX_BITS; index++) begin
         write_reg(CSR_INDEX_BITS'(index), 32'd0);
      end
      send_pixel(12'd512, 12'd512);
      send_pixel(12'd256, 12'd512);
      drain_pixels();
   endtask

   // Most negative and most positive origins and steps.
   task automatic test_register_extremes();
      write_reg(CSR_X_ORIGIN, 32'h8000_0000);
      write_reg(CSR_X_STEP, 32'h7FFF_FFFF);
      write_reg(CSR_Y_ORIGIN, 32'h7FFF_FFFF);
      write_reg(CSR_Y_STEP, 32'h8000_0000);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd4095, 12'd4095);
      drain_pixels();
      restore_defaults();
   endtask

   // Highest limit on a point that never escapes: the count saturates there.
   task automatic test_deep_limit();
      write_reg(CSR_MAX_ITERATIONS, 32'd65535);
      send_pixel(12'd512, 12'd512);
      drain_pixels();
      write_reg(CSR_MAX_ITERATIONS, REG_BITS'(MAX_ITERATIONS_RESET));
   endtask

   // Random windows centered near the set, each group with its own registers.
   task automatic test_random_views(input int idle_pct, input int stall_pct);
      int                    center_x, center_y, step_x, step_y;
      logic [COUNT_BITS-1:0] limit;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int group = 0; group < 3; group++) begin
         drain_pixels();
         center_x = 80530636 - int'($urandom_range(0, 483183820));
         center_y = int'($urandom_range(0, 644245094)) - 322122547;
         step_x   = int'($urandom_range(1 << 12, 1 << 19));
         step_y   = int'($urandom_range(1 << 12, 1 << 19));
         if ($urandom_range(0, 3) == 0) step_x = -step_x;
         if ($urandom_range(0, 3) == 0) step_y = -step_y;
         if ($urandom_range(0, 19) == 0) begin
            limit = COUNT_BITS'($urandom_range(0, 3));
         end else begin
            limit = COUNT_BITS'($urandom_range(1, 600));
         end
         write_reg(CSR_MAX_ITERATIONS, {16'($urandom), limit});
         write_reg(CSR_X_ORIGIN, REG_BITS'(center_x - 2048 * step_x));
         write_reg(CSR_X_STEP, REG_BITS'(step_x));
         write_reg(CSR_Y_ORIGIN, REG_BITS'(center_y - 2048 * step_y));
         write_reg(CSR_Y_STEP, REG_BITS'(step_y));
         for (int n = 0; n < 50; n++) begin
            send_pixel(COLUMN_BITS'($urandom_range(0, 4095)),
                       ROW_BITS'($urandom_range(0, 4095)));
         end
      end
      drain_pixels();
   endtask

   // Receiver: random back-pressure changed at the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Response check against the oldest prediction.
   always @(posedge clock) begin
      pixel_result_type actual, predicted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         actual.column = rsp_tdata[COLUMN_BITS-1:0];
         actual.row    = rsp_tdata[COLUMN_BITS +: ROW_BITS];
         actual.count  = rsp_tdata[COLUMN_BITS+ROW_BITS +: COUNT_BITS];
         if (pending_pixels.size() == 0) begin
            note_mismatch("unexpected response column", 0, actual.column);
         end else begin
            predicted = pending_pixels.pop_front();
            if (actual.column != predicted.column) begin
               note_mismatch("result_column", predicted.column, actual.column);
            end
            if (actual.row != predicted.row) begin
               note_mismatch("result_row", predicted.row, actual.row);
            end
            if (actual.count != predicted.count) begin
               note_mismatch("escape_count", predicted.count, actual.count);
            end
         end
      end
   end

   // Watchdog: too many cycles without any transfer ends the run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
         $display("tb_mandelbrot_escape_time: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_view();
      test_iteration_limits();
      test_unused_indexes();
      test_register_extremes();
      test_deep_limit();
      test_random_views(0, 0);
      test_random_views(47, 0);
      test_random_views(0, 47);
      test_random_views(24, 24);

      drain_pixels();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("tb_mandelbrot_escape_time: clean");
      end else begin
         $display("tb_mandelbrot_escape_time: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
